// ===== hw/rtl/rtdc_pkg.sv =====
// Shared types and constants for the RTD code to temperature converter.
// Holds the fixed-point coefficients, field widths and the item sideband.
// No dependencies.
`timescale 1ns / 1ps

package rtdc_pkg;

  // Field and datapath widths.
  localparam int CODE_W = 15;
  localparam int REG_W  = 23;
  localparam int XQ_W   = 36;
  localparam int DISC_W = 49;
  localparam int ROOT_W = 25;
  localparam int QT_W   = 19;
  localparam int DEN_W  = 26;
  localparam int NUM_W  = 43;
  localparam int TEMP_W = 18;

  // Callendar-Van Dusen coefficients: A scaled by 2^32, |B| scaled by 2^48.
  localparam logic [24:0] CVD_A_Q = 25'd16786021;
  localparam logic [27:0] CVD_B_Q = 28'd162551799;
  localparam logic [DISC_W-1:0] CVD_A2_Q =
    DISC_W'({25'd0, CVD_A_Q} * {25'd0, CVD_A_Q});

  // Result limits and the linear fallback offset.
  localparam logic signed [TEMP_W-1:0] TEMP_MAX_CENTI = 18'sd100000;
  localparam logic signed [TEMP_W-1:0] LIN_OFFSET     = 18'sd256;
  localparam logic signed [TEMP_W-1:0] LIN_SCALE      = 18'sd100;

  // Configuration register reset values.
  localparam logic [REG_W-1:0] REF_RES_RESET = 23'd430000;
  localparam logic [REG_W-1:0] NOM_RES_RESET = 23'd101700;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    REG_REF_RES = 1'b0,
    REG_NOM_RES = 1'b1
  } reg_idx_t;

  // Sideband that travels with each item through the pipeline.
  typedef struct packed {
    logic                     valid;
    logic                     lin;
    logic                     sat;
    logic signed [TEMP_W-1:0] lin_temp;
  } side_t;

endpackage

// ===== hw/rtl/rtdc_xq_div.sv =====
// Pipelined restoring divider for xq = (d << 32) / r0, one quotient bit per stage.
// Depends on rtdc_pkg.
`timescale 1ns / 1ps

module rtdc_xq_div import rtdc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  side_t            side_i,
  input  logic [REG_W-1:0] d_i,
  input  logic [REG_W-1:0] r0_i,
  output side_t            side_o,
  output logic [XQ_W-1:0]  xq_o
);

  side_t             side_r [XQ_W];
  logic [REG_W:0]    rem_r  [XQ_W];
  logic [XQ_W-1:0]   q_r    [XQ_W];
  logic [3:0]        lo_r   [XQ_W];

  for (genvar i = 0; i < XQ_W; i++) begin : g_step
    side_t           side_cur;
    logic [REG_W:0]  rem_cur;
    logic [XQ_W-1:0] q_cur;
    logic [3:0]      lo_cur;
    logic [REG_W:0]  shifted;
    logic            fits;

    // The first stage starts from the top bits of d; the quotient's upper bits are zero.
    if (i == 0) begin : g_first
      assign side_cur = side_i;
      assign rem_cur  = {5'd0, d_i[REG_W-1:4]};
      assign q_cur    = '0;
      assign lo_cur   = d_i[3:0];
    end else begin : g_next
      assign side_cur = side_r[i-1];
      assign rem_cur  = rem_r[i-1];
      assign q_cur    = q_r[i-1];
      assign lo_cur   = lo_r[i-1];
    end

    // Bring down one dividend bit and try a subtract.
    assign shifted = {rem_cur[REG_W-1:0], lo_cur[3]};
    assign fits    = shifted >= {1'b0, r0_i};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        side_r[i].valid <= 1'b0;
      end else begin
        side_r[i] <= side_cur;
      end
      rem_r[i]  <= fits ? (shifted - {1'b0, r0_i}) : shifted;
      q_r[i]    <= {q_cur[XQ_W-2:0], fits};
      lo_r[i]   <= {lo_cur[2:0], 1'b0};
    end
  end

  assign side_o = side_r[XQ_W-1];
  assign xq_o   = q_r[XQ_W-1];

endmodule

// ===== hw/rtl/rtdc_disc.sv =====
// Discriminant stages: B*xq split into two partial products, summed, then
// subtracted from A^2 with a saturation check. Depends on rtdc_pkg.
`timescale 1ns / 1ps

module rtdc_disc import rtdc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  side_t             side_i,
  input  logic [XQ_W-1:0]   xq_i,
  output side_t             side_o,
  output logic [XQ_W-1:0]   xq_o,
  output logic [DISC_W-1:0] disc_o
);

  side_t             side1_r, side2_r, side3_r;
  side_t             side3_nxt;
  logic [XQ_W-1:0]   xq1_r, xq2_r, xq3_r;
  logic [45:0]       p_lo_r, p_hi_r;
  logic [63:0]       full_r;
  logic [DISC_W-1:0] disc_r;
  logic [DISC_W:0]   bx;
  logic              over;

  // The product bits from 2^14 up form 4*B*x at the 2^64 scale of A^2.
  assign bx   = full_r[63:14];
  assign over = bx > {1'b0, CVD_A2_Q};

  // A negative discriminant saturates the result.
  always_comb begin
    side3_nxt     = side2_r;
    side3_nxt.sat = side2_r.sat | over;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side1_r.valid <= 1'b0;
      side2_r.valid <= 1'b0;
      side3_r.valid <= 1'b0;
    end else begin
      side1_r <= side_i;
      side2_r <= side1_r;
      side3_r <= side3_nxt;
    end
    // Partial products on the low and high halves of xq.
    xq1_r   <= xq_i;
    p_lo_r  <= {18'd0, CVD_B_Q} * {28'd0, xq_i[17:0]};
    p_hi_r  <= {18'd0, CVD_B_Q} * {28'd0, xq_i[35:18]};
    // Recombine the partial products.
    xq2_r   <= xq1_r;
    full_r  <= {p_hi_r, 18'd0} + {18'd0, p_lo_r};
    // A^2 minus B*xq.
    xq3_r   <= xq2_r;
    disc_r  <= CVD_A2_Q - bx[DISC_W-1:0];
  end

  assign side_o = side3_r;
  assign xq_o   = xq3_r;
  assign disc_o = disc_r;

endmodule

// ===== hw/rtl/rtdc_sqrt.sv =====
// Pipelined integer square root, one root bit per stage.
// Depends on rtdc_pkg.
`timescale 1ns / 1ps

module rtdc_sqrt import rtdc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  side_t             side_i,
  input  logic [XQ_W-1:0]   xq_i,
  input  logic [DISC_W-1:0] disc_i,
  output side_t             side_o,
  output logic [XQ_W-1:0]   xq_o,
  output logic [ROOT_W-1:0] root_o
);

  side_t             side_r [ROOT_W];
  logic [XQ_W-1:0]   xq_r   [ROOT_W];
  logic [49:0]       v_r    [ROOT_W];
  logic [27:0]       rem_r  [ROOT_W];
  logic [ROOT_W-1:0] root_r [ROOT_W];

  for (genvar i = 0; i < ROOT_W; i++) begin : g_step
    side_t             side_cur;
    logic [XQ_W-1:0]   xq_cur;
    logic [49:0]       v_cur;
    logic [27:0]       rem_cur;
    logic [ROOT_W-1:0] root_cur;
    logic [27:0]       cand;
    logic [27:0]       trial;
    logic              fits;

    if (i == 0) begin : g_first
      assign side_cur = side_i;
      assign xq_cur   = xq_i;
      assign v_cur    = {1'b0, disc_i};
      assign rem_cur  = '0;
      assign root_cur = '0;
    end else begin : g_next
      assign side_cur = side_r[i-1];
      assign xq_cur   = xq_r[i-1];
      assign v_cur    = v_r[i-1];
      assign rem_cur  = rem_r[i-1];
      assign root_cur = root_r[i-1];
    end

    // Bring down two radicand bits and test the next root bit.
    assign cand  = {rem_cur[25:0], v_cur[49:48]};
    assign trial = {1'b0, root_cur, 2'b01};
    assign fits  = cand >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        side_r[i].valid <= 1'b0;
      end else begin
        side_r[i] <= side_cur;
      end
      xq_r[i]   <= xq_cur;
      v_r[i]    <= {v_cur[47:0], 2'b00};
      rem_r[i]  <= fits ? (cand - trial) : cand;
      root_r[i] <= {root_cur[ROOT_W-2:0], fits};
    end
  end

  assign side_o = side_r[ROOT_W-1];
  assign xq_o   = xq_r[ROOT_W-1];
  assign root_o = root_r[ROOT_W-1];

endmodule

// ===== hw/rtl/rtdc_temp_div.sv =====
// Final pipelined divider: temp = 200*xq / (A + root), one quotient bit per stage.
// Depends on rtdc_pkg.
`timescale 1ns / 1ps

module rtdc_temp_div import rtdc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  side_t             side_i,
  input  logic [XQ_W-1:0]   xq_i,
  input  logic [ROOT_W-1:0] root_i,
  output side_t             side_o,
  output logic [QT_W-1:0]   quot_o
);

  side_t            side_p_r;
  logic [NUM_W-1:0] num_r;
  logic [DEN_W-1:0] den_p_r;

  side_t            side_r [QT_W];
  logic [DEN_W:0]   rem_r  [QT_W];
  logic [QT_W-1:0]  lo_r   [QT_W];
  logic [DEN_W-1:0] den_r  [QT_W];
  logic [QT_W-1:0]  q_r    [QT_W];

  // Numerator and denominator are formed a stage ahead of the divider.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_p_r.valid <= 1'b0;
    end else begin
      side_p_r <= side_i;
    end
    num_r    <= {7'd0, xq_i} * 43'd200;
    den_p_r  <= {1'b0, CVD_A_Q} + {1'b0, root_i};
  end

  for (genvar i = 0; i < QT_W; i++) begin : g_step
    side_t            side_cur;
    logic [DEN_W:0]   rem_cur;
    logic [QT_W-1:0]  lo_cur;
    logic [DEN_W-1:0] den_cur;
    logic [QT_W-1:0]  q_cur;
    logic [DEN_W:0]   cand;
    logic             fits;

    // The denominator is at least 2^24, so the top numerator bits start below it.
    if (i == 0) begin : g_first
      assign side_cur = side_p_r;
      assign rem_cur  = {3'd0, num_r[NUM_W-1:QT_W]};
      assign lo_cur   = num_r[QT_W-1:0];
      assign den_cur  = den_p_r;
      assign q_cur    = '0;
    end else begin : g_next
      assign side_cur = side_r[i-1];
      assign rem_cur  = rem_r[i-1];
      assign lo_cur   = lo_r[i-1];
      assign den_cur  = den_r[i-1];
      assign q_cur    = q_r[i-1];
    end

    assign cand = {rem_cur[DEN_W-1:0], lo_cur[QT_W-1]};
    assign fits = cand >= {1'b0, den_cur};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        side_r[i].valid <= 1'b0;
      end else begin
        side_r[i] <= side_cur;
      end
      rem_r[i]  <= fits ? (cand - {1'b0, den_cur}) : cand;
      lo_r[i]   <= {lo_cur[QT_W-2:0], 1'b0};
      den_r[i]  <= den_cur;
      q_r[i]    <= {q_cur[QT_W-2:0], fits};
    end
  end

  assign side_o = side_r[QT_W-1];
  assign quot_o = q_r[QT_W-1];

endmodule

// ===== hw/rtl/rtd_code_to_temperature.sv =====
// Top level of the RTD code to temperature converter: configuration registers,
// front stages, output register. Depends on rtdc_pkg and the rtdc_* stage modules.
//
//   channel  ports                                     handshake
//   input    in_rtd_word                               start & !busy
//   result   out_temp_centi, out_used_linear           out_valid strobe, one cycle
//   config   cfg_index, cfg_data                       cfg_we
//
// One item may be started in every cycle; busy is always low.
// Each result follows its item through the front stages, the
// three bit-per-stage units (36-stage divider, 25-stage root, 19-stage divider) and the output register.
// Synchronous active-low reset clears all valid bits and loads the default
// register values. The receiver cannot stall, so nothing ever holds the pipeline.
`timescale 1ns / 1ps

module rtd_code_to_temperature import rtdc_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [15:0]              in_rtd_word,
  output logic                     out_valid,
  output logic signed [TEMP_W-1:0] out_temp_centi,
  output logic                     out_used_linear,
  input  logic                     cfg_we,
  input  reg_idx_t                 cfg_index,
  input  logic [REG_W-1:0]         cfg_data
);

  logic [REG_W-1:0] ref_r, nom_r;
  logic [REG_W-1:0] r0;

  side_t            side1_r, side2_r, side3_r;
  logic [37:0]      prod_r;
  logic [9:0]       code_hi_r;
  logic [REG_W-1:0] d2_r, d3_r;

  logic [REG_W-1:0]         res_mohm;
  logic signed [TEMP_W-1:0] lin_base;
  logic signed [TEMP_W-1:0] lin_temp;
  side_t                    side1_nxt;
  side_t                    side2_nxt;
  side_t                    side3_nxt;

  side_t             div_side, disc_side, sqrt_side, fin_side;
  logic [XQ_W-1:0]   div_xq, disc_xq, sqrt_xq;
  logic [DISC_W-1:0] disc;
  logic [ROOT_W-1:0] root;
  logic [QT_W-1:0]   quot;

  logic                     out_valid_r;
  logic signed [TEMP_W-1:0] temp_r;
  logic                     lin_r;
  logic signed [TEMP_W-1:0] temp_nxt;

  assign busy = 1'b0;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_r <= REF_RES_RESET;
      nom_r <= NOM_RES_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_REF_RES: ref_r <= cfg_data;
        REG_NOM_RES: nom_r <= cfg_data;
        default:     ref_r <= ref_r;
      endcase
    end
  end

  // A zero nominal resistance is treated as one milliohm.
  assign r0 = (nom_r == '0) ? 23'd1 : nom_r;

  // Stage 2 logic: resistance, fallback test and linear fallback value.
  assign res_mohm = prod_r[37:15];
  assign lin_base = $signed({8'd0, code_hi_r}) - LIN_OFFSET;
  assign lin_temp = TEMP_W'(lin_base * LIN_SCALE);

  always_comb begin
    side1_nxt          = '0;
    side1_nxt.valid    = start & ~busy;
    side2_nxt          = side1_r;
    side2_nxt.lin      = res_mohm < r0;
    side2_nxt.sat      = 1'b0;
    side2_nxt.lin_temp = lin_temp;
    side3_nxt          = side2_r;
    side3_nxt.sat      = {3'd0, d2_r} > {r0, 3'b000};
  end

  // Front stages: code times reference, then resistance, then the range check.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side1_r.valid <= 1'b0;
      side2_r.valid <= 1'b0;
      side3_r.valid <= 1'b0;
    end else begin
      side1_r <= side1_nxt;
      side2_r <= side2_nxt;
      side3_r <= side3_nxt;
    end
    prod_r        <= {23'd0, in_rtd_word[15:1]} * {15'd0, ref_r};
    code_hi_r     <= in_rtd_word[15:6];
    d2_r          <= res_mohm - r0;
    d3_r          <= d2_r;
  end

  rtdc_xq_div u_xq_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .side_i (side3_r),
    .d_i    (d3_r),
    .r0_i   (r0),
    .side_o (div_side),
    .xq_o   (div_xq)
  );

  rtdc_disc u_disc (
    .clk    (clk),
    .rst_n  (rst_n),
    .side_i (div_side),
    .xq_i   (div_xq),
    .side_o (disc_side),
    .xq_o   (disc_xq),
    .disc_o (disc)
  );

  rtdc_sqrt u_sqrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .side_i (disc_side),
    .xq_i   (disc_xq),
    .disc_i (disc),
    .side_o (sqrt_side),
    .xq_o   (sqrt_xq),
    .root_o (root)
  );

  rtdc_temp_div u_temp_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .side_i (sqrt_side),
    .xq_i   (sqrt_xq),
    .root_i (root),
    .side_o (fin_side),
    .quot_o (quot)
  );

  // Pick the fallback, the saturated value or the solved quotient.
  always_comb begin
    if (fin_side.lin) begin
      temp_nxt = fin_side.lin_temp;
    end else if (fin_side.sat || (quot > 19'd100000)) begin
      temp_nxt = TEMP_MAX_CENTI;
    end else begin
      temp_nxt = $signed(quot[TEMP_W-1:0]);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= fin_side.valid;
    end
    temp_r <= temp_nxt;
    lin_r  <= fin_side.lin;
  end

  assign out_valid       = out_valid_r;
  assign out_temp_centi  = temp_r;
  assign out_used_linear = lin_r;

endmodule

// ===== tb/rtd_code_to_temperature_tb.sv =====
// Self-checking testbench for the RTD code to temperature converter.
// Drives words through a directed table and random phases, and predicts each result
// in SystemVerilog. Depends on rtdc_pkg and the rtd_code_to_temperature RTL.
`timescale 1ns / 1ps

module rtd_code_to_temperature_tb;
  import rtdc_pkg::*;

  localparam int LATENCY = 88;
  localparam longint unsigned A_COEF = 64'd16786021;
  localparam longint unsigned B_COEF = 64'd162551799;
  localparam longint unsigned T_MAX  = 64'd100000;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     start = 1'b0;
  logic                     busy;
  logic [15:0]              in_rtd_word = '0;
  logic                     out_valid;
  logic signed [TEMP_W-1:0] out_temp_centi;
  logic                     out_used_linear;
  logic                     cfg_we = 1'b0;
  reg_idx_t                 cfg_index = REG_REF_RES;
  logic [REG_W-1:0]         cfg_data = '0;

  // The testbench's copy of the two resistance registers.
  logic [REG_W-1:0] ref_res_q = REF_RES_RESET;
  logic [REG_W-1:0] nom_res_q = NOM_RES_RESET;

  // Temperatures and fallback flags still due from the block.
  logic signed [TEMP_W-1:0] due_temp[$];
  logic                     due_lin[$];

  int errors = 0;
  int n_items = 0;
  int n_results = 0;
  int n_linear = 0;
  int n_sat = 0;
  bit no_idle = 1'b0;

  rtd_code_to_temperature i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_rtd_word(in_rtd_word), .out_valid(out_valid),
    .out_temp_centi(out_temp_centi), .out_used_linear(out_used_linear),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Bitwise integer square root, floor.
  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Callendar-Van Dusen conversion of one word under the current registers.
  function automatic void convert_word(input logic [15:0] w,
                                       output logic signed [TEMP_W-1:0] t,
                                       output logic lin);
    longint unsigned code, r, r0, d, xq, a2, bx, s, q;
    code = w[15:1];
    r = (code * ref_res_q) >> 15;
    r0 = (nom_res_q == 0) ? 64'd1 : nom_res_q;
    lin = 1'b0;
    if (r < r0) begin
      t = TEMP_W'((longint'(code >> 5) - 256) * 100);
      lin = 1'b1;
    end else begin
      d = r - r0;
      a2 = A_COEF * A_COEF;
      q = T_MAX;
      if (d <= 8 * r0) begin
        xq = (d << 32) / r0;
        bx = (B_COEF * xq) >> 14;
        if (bx <= a2) begin
          s = int_sqrt(a2 - bx);
          q = (200 * xq) / (A_COEF + s);
          if (q > T_MAX) q = T_MAX;
        end
      end
      t = TEMP_W'(q);
    end
  endfunction

  // Compare every result with the oldest temperature still due.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      n_results++;
      if (due_temp.size() == 0) begin
        $error("result with nothing due: temp_centi=%0d", out_temp_centi);
        errors++;
      end else begin
        if (out_temp_centi !== due_temp[0]) begin
          $error("temp_centi: expected %0d, actual %0d", due_temp[0], out_temp_centi);
          errors++;
        end
        if (out_used_linear !== due_lin[0]) begin
          $error("used_linear: expected %0b, actual %0b", due_lin[0], out_used_linear);
          errors++;
        end
        void'(due_temp.pop_front());
        void'(due_lin.pop_front());
      end
    end
  end

  // Wait until every result is in, then write both registers.
  task automatic set_resistances(input logic [REG_W-1:0] rref, input logic [REG_W-1:0] rnom);
    start <= 1'b0;
    @(posedge clk);
    while (due_temp.size() != 0) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= REG_REF_RES;
    cfg_data <= rref;
    @(posedge clk);
    cfg_index <= REG_NOM_RES;
    cfg_data <= rnom;
    @(posedge clk);
    cfg_we <= 1'b0;
    ref_res_q = rref;
    nom_res_q = rnom;
  endtask

  // Offer one word, record its prediction on acceptance, then maybe idle a while.
  task automatic send_word(input logic [15:0] w, input bit chk,
                           input logic signed [TEMP_W-1:0] t_typed, input logic lin_typed);
    logic signed [TEMP_W-1:0] t;
    logic lin;
    start <= 1'b1;
    in_rtd_word <= w;
    do @(posedge clk); while (busy);
    convert_word(w, t, lin);
    if (chk && (t !== t_typed || lin !== lin_typed)) begin
      $error("table row for word %h: expected %0d/%0b, predicted %0d/%0b",
             w, t_typed, lin_typed, t, lin);
      errors++;
    end
    due_temp.push_back(t);
    due_lin.push_back(lin);
    n_items++;
    if (lin) n_linear++;
    if (!lin && t == TEMP_MAX_CENTI) n_sat++;
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  typedef struct {
    logic [REG_W-1:0]         rref;
    logic [REG_W-1:0]         rnom;
    logic [15:0]              word;
    bit                       chk;
    logic signed [TEMP_W-1:0] temp;
    logic                     lin;
  } row_t;

  // Directed rows; the temperature is typed in only where it is obvious.
  row_t dir_rows[] = '{
    '{23'd430000, 23'd101700, 16'h0000, 1, -18'sd25600, 1'b1},
    '{23'd430000, 23'd101700, 16'h0001, 1, -18'sd25600, 1'b1},
    '{23'd430000, 23'd101700, 16'hFFFF, 0, 18'sd0, 1'b0},
    '{23'd430000, 23'd101700, 16'h3CAE, 0, 18'sd0, 1'b0},
    '{23'd430000, 23'd101700, 16'hAAAA, 0, 18'sd0, 1'b0},
    '{23'd430000, 23'd101700, 16'h5555, 0, 18'sd0, 1'b0},
    '{23'd32768, 23'd5000, 16'd10000, 1, 18'sd0, 1'b0},
    '{23'd32768, 23'd5000, 16'd9998, 1, -18'sd10000, 1'b1},
    '{23'd32768, 23'd5000, 16'd10001, 1, 18'sd0, 1'b0},
    '{23'd32768, 23'd5000, 16'd10002, 0, 18'sd0, 1'b0},
    '{23'd32768, 23'd1000, 16'hFFFF, 1, 18'sd100000, 1'b0},
    '{23'd32768, 23'd1000, 16'd18002, 0, 18'sd0, 1'b0},
    '{23'd32768, 23'd1000, 16'd18000, 0, 18'sd0, 1'b0},
    '{23'd0, 23'd101700, 16'hFFFF, 1, 18'sd76700, 1'b1},
    '{23'd32768, 23'd0, 16'h0002, 1, 18'sd0, 1'b0},
    '{23'd32768, 23'd0, 16'h0000, 1, -18'sd25600, 1'b1},
    '{23'd32768, 23'd0, 16'hFFFF, 1, 18'sd100000, 1'b0},
    '{23'h7FFFFF, 23'h7FFFFF, 16'hFFFF, 1, 18'sd76700, 1'b1},
    '{23'h7FFFFF, 23'd1, 16'hFFFF, 1, 18'sd100000, 1'b0},
    '{23'h7FFFFF, 23'd2000000, 16'hFFFF, 0, 18'sd0, 1'b0},
    '{23'd1, 23'd1, 16'hFFFF, 0, 18'sd0, 1'b0},
    '{23'd1, 23'd1, 16'h0002, 1, -18'sd25600, 1'b1}
  };

  // Random phases: pairs of reference and nominal values.
  logic [REG_W-1:0] ph_ref[] = '{23'd430000, 23'd400000, 23'h7FFFFF, 23'd4000000,
                                 23'd0, 23'd32768, 23'd430000};
  logic [REG_W-1:0] ph_nom[] = '{23'd101700, 23'd100000, 23'd1000000, 23'h7FFFFF,
                                 23'd101700, 23'd0, 23'd101700};

  initial begin
    logic [15:0] w;
    logic [REG_W-1:0] rr, rn;
    longint unsigned nom_code;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part.
    foreach (dir_rows[i]) begin
      if (dir_rows[i].rref != ref_res_q || dir_rows[i].rnom != nom_res_q)
        set_resistances(dir_rows[i].rref, dir_rows[i].rnom);
      send_word(dir_rows[i].word, dir_rows[i].chk, dir_rows[i].temp, dir_rows[i].lin);
    end

    // Random part: fixed phases, then two with random registers.
    for (int p = 0; p < 9; p++) begin
      if (p < 7) begin
        rr = ph_ref[p];
        rn = ph_nom[p];
      end else begin
        rr = REG_W'($urandom_range(1, 23'h7FFFFF));
        rn = REG_W'($urandom_range(1, 23'h7FFFFF));
      end
      set_resistances(rr, rn);
      no_idle = (p == 8);
      // Word whose resistance sits near the nominal value.
      nom_code = (ref_res_q == 0) ? 64'd0 :
                 ((longint'(nom_res_q) << 15) / ref_res_q);
      for (int k = 0; k < 75; k++) begin
        if ($urandom_range(0, 2) == 0 && nom_code < 32768)
          w = {15'(nom_code + $urandom_range(0, 6) - 3), 1'($urandom_range(0, 1))};
        else
          w = 16'($urandom);
        send_word(w, 0, '0, 1'b0);
      end
    end

    start <= 1'b0;
    while (due_temp.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    $display("Sent %0d words over the directed table and nine register phases:",
             n_items);
    $display("  %0d linear fallbacks, %0d saturated.", n_linear, n_sat);
    if (errors == 0 && due_temp.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end

endmodule
